@@ sv/cdff_pkg.sv @@
// Shared types, widths and codes for the central-difference face flux block.
// No dependencies; every other file imports this package.
package cdff_pkg;

  localparam int unsigned VAL_W  = 48;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned COMP_W = 5;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned OPA_W  = VAL_W + 1;
  localparam int unsigned LO_W   = 24;
  localparam int unsigned PROD_W = OPA_W + VAL_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned NMUL   = 4;

  localparam int unsigned MAX_COMPONENTS = 32;
  localparam logic [COMP_W:0] COMP_LIMIT = (COMP_W + 1)'(MAX_COMPONENTS);

  localparam logic [FUNC_W-1:0] FUNC_AREA  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KIN_L = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_KIN_R = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PAIR  = 2'd3;

  localparam logic [COMP_W-1:0] COMP_MASS   = 5'd0;
  localparam logic [COMP_W-1:0] COMP_MOM_X  = 5'd1;
  localparam logic [COMP_W-1:0] COMP_MOM_Y  = 5'd2;
  localparam logic [COMP_W-1:0] COMP_MOM_Z  = 5'd3;
  localparam logic [COMP_W-1:0] COMP_ENERGY = 5'd4;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    K_AREA,
    K_KIN_L,
    K_KIN_R,
    K_MOM,
    K_ENERGY,
    K_SPECIES
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [COMP_W-1:0] comp;
  } meta_t;

  typedef struct packed {
    logic [NMUL-1:0][OPA_W-1:0] a;
    logic [NMUL-1:0][VAL_W-1:0] b;
    meta_t                      meta;
  } opnd_t;

  typedef struct packed {
    logic [NMUL-1:0][2*LO_W-1:0] ll;
    logic [NMUL-1:0][2*LO_W:0]   lh;
    logic [NMUL-1:0][2*LO_W+1:0] hl;
    logic [NMUL-1:0][2*LO_W:0]   hh;
    meta_t                       meta;
  } part_t;

  typedef struct packed {
    logic [NMUL-1:0][PROD_W-1:0] p;
    meta_t                       meta;
  } prod_t;

  typedef struct packed {
    val_t  flux;
    val_t  mass;
    meta_t meta;
  } rnd_t;

  typedef struct packed {
    logic we;
    logic right;
    val_t value;
  } ufwr_t;

  function automatic logic [OPA_W-1:0] ext_opa(input val_t v);
    return {v[VAL_W-1], v};
  endfunction

  function automatic logic is_kin(input kind_e k);
    return (k == K_KIN_L) || (k == K_KIN_R);
  endfunction

endpackage

@@ sv/cdff_front.sv @@
// Input register, face state (area, pressures, normal velocities) and operand
// selection for the four multipliers. Depends on cdff_pkg.
module cdff_front import cdff_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  val_t              area_x_i,
  input  val_t              area_y_i,
  input  val_t              area_z_i,
  input  val_t              vel_x_i,
  input  val_t              vel_y_i,
  input  val_t              vel_z_i,
  input  val_t              pressure_i,
  input  logic [COMP_W-1:0] component_i,
  input  val_t              left_value_i,
  input  val_t              right_value_i,
  input  ufwr_t             ufwr_i,
  input  logic              kin_busy_i,
  output logic              opnd_valid_o,
  input  logic              opnd_ready_i,
  output opnd_t             opnd_o
);

  logic              s1_v_q;
  logic [FUNC_W-1:0] s1_func_q;
  logic [COMP_W-1:0] s1_comp_q;
  val_t              s1_vel_q [3];
  val_t              s1_left_q;
  val_t              s1_right_q;

  val_t              area_q [3];
  val_t              pl_q;
  val_t              pr_q;
  val_t              ufl_q;
  val_t              ufr_q;

  logic              s2_v_q;
  opnd_t             s2_q;
  opnd_t             opnd_d;

  logic              accept;
  logic              keep;
  logic              s1_ready;
  logic              s1_adv;
  logic              s2_ready;
  logic              hazard;
  val_t              area_sel;

  assign keep = (func_i != FUNC_PAIR) ||
                ((component_i != COMP_MASS) && ({1'b0, component_i} < COMP_LIMIT));

  assign s2_ready   = !s2_v_q || opnd_ready_i;
  assign hazard     = (s1_func_q == FUNC_PAIR) &&
                      (kin_busy_i || (s2_v_q && is_kin(s2_q.meta.kind)));
  assign s1_adv     = s1_v_q && s2_ready && !hazard;
  assign s1_ready   = !s1_v_q || s1_adv;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= accept && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= func_i;
      s1_comp_q   <= component_i;
      s1_vel_q[0] <= vel_x_i;
      s1_vel_q[1] <= vel_y_i;
      s1_vel_q[2] <= vel_z_i;
      s1_left_q   <= left_value_i;
      s1_right_q  <= right_value_i;
    end
  end

  // Area and pressure are taken at acceptance; normal velocity comes back from rounding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        area_q[i] <= '0;
      end
      pl_q  <= '0;
      pr_q  <= '0;
      ufl_q <= '0;
      ufr_q <= '0;
    end else begin
      if (accept && (func_i == FUNC_AREA)) begin
        area_q[0] <= area_x_i;
        area_q[1] <= area_y_i;
        area_q[2] <= area_z_i;
      end
      if (accept && (func_i == FUNC_KIN_L)) begin
        pl_q <= pressure_i;
      end
      if (accept && (func_i == FUNC_KIN_R)) begin
        pr_q <= pressure_i;
      end
      if (ufwr_i.we && !ufwr_i.right) begin
        ufl_q <= ufwr_i.value;
      end
      if (ufwr_i.we && ufwr_i.right) begin
        ufr_q <= ufwr_i.value;
      end
    end
  end

  always_comb begin
    case (s1_comp_q)
      COMP_MOM_X: area_sel = area_q[0];
      COMP_MOM_Y: area_sel = area_q[1];
      COMP_MOM_Z: area_sel = area_q[2];
      default:    area_sel = '0;
    endcase
  end

  always_comb begin
    opnd_d           = '0;
    opnd_d.meta.comp = s1_comp_q;
    case (s1_func_q)
      FUNC_AREA: begin
        opnd_d.meta.kind = K_AREA;
      end
      FUNC_KIN_L, FUNC_KIN_R: begin
        opnd_d.meta.kind = (s1_func_q == FUNC_KIN_L) ? K_KIN_L : K_KIN_R;
        for (int i = 0; i < 3; i++) begin
          opnd_d.a[i] = ext_opa(area_q[i]);
          opnd_d.b[i] = s1_vel_q[i];
        end
      end
      FUNC_PAIR: begin
        if ((s1_comp_q == COMP_MOM_X) || (s1_comp_q == COMP_MOM_Y) ||
            (s1_comp_q == COMP_MOM_Z)) begin
          opnd_d.meta.kind = K_MOM;
        end else if (s1_comp_q == COMP_ENERGY) begin
          opnd_d.meta.kind = K_ENERGY;
        end else begin
          opnd_d.meta.kind = K_SPECIES;
        end
        opnd_d.a[0] = ext_opa(s1_right_q);
        opnd_d.a[1] = ext_opa(s1_left_q);
        if (s1_comp_q == COMP_ENERGY) begin
          opnd_d.a[0] = ext_opa(s1_right_q) + ext_opa(pr_q);
          opnd_d.a[1] = ext_opa(s1_left_q) + ext_opa(pl_q);
        end
        opnd_d.b[0] = ufr_q;
        opnd_d.b[1] = ufl_q;
        opnd_d.a[2] = (opnd_d.meta.kind == K_MOM) ? ext_opa(pl_q) + ext_opa(pr_q) : '0;
        opnd_d.b[2] = area_sel;
        opnd_d.a[3] = ext_opa(s1_right_q) + ext_opa(s1_left_q);
        opnd_d.b[3] = area_sel;
      end
      default: begin
        opnd_d.meta.kind = K_AREA;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q <= opnd_d;
    end
  end

  assign opnd_valid_o = s2_v_q;
  assign opnd_o       = s2_q;

endmodule

@@ sv/cdff_mul.sv @@
// Two-stage multiplier bank: partial products of 24-bit slices, then full 97-bit products.
// Depends on cdff_pkg.
module cdff_mul import cdff_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  opnd_t opnd_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prod_t prod_o,
  output logic  kin_busy_o
);

  logic  s3_v_q;
  part_t s3_q;
  part_t part_d;
  logic  s4_v_q;
  prod_t s4_q;
  prod_t prod_d;
  logic  s3_ready;
  logic  s4_ready;

  assign s4_ready = !s4_v_q || ready_i;
  assign s3_ready = !s3_v_q || s4_ready;
  assign ready_o  = s3_ready;

  always_comb begin
    part_d.meta = opnd_i.meta;
    for (int i = 0; i < NMUL; i++) begin
      part_d.ll[i] = opnd_i.a[i][LO_W-1:0] * opnd_i.b[i][LO_W-1:0];
      part_d.lh[i] = $signed({1'b0, opnd_i.a[i][LO_W-1:0]}) *
                     $signed(opnd_i.b[i][VAL_W-1:LO_W]);
      part_d.hl[i] = $signed(opnd_i.a[i][OPA_W-1:LO_W]) *
                     $signed({1'b0, opnd_i.b[i][LO_W-1:0]});
      part_d.hh[i] = $signed(opnd_i.a[i][OPA_W-1:LO_W]) *
                     $signed(opnd_i.b[i][VAL_W-1:LO_W]);
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] t_ll;
    logic signed [PROD_W-1:0] t_lh;
    logic signed [PROD_W-1:0] t_hl;
    logic signed [PROD_W-1:0] t_hh;
    prod_d.meta = s3_q.meta;
    for (int i = 0; i < NMUL; i++) begin
      t_ll = $signed(PROD_W'(s3_q.ll[i]));
      t_lh = PROD_W'($signed(s3_q.lh[i]));
      t_hl = PROD_W'($signed(s3_q.hl[i]));
      t_hh = PROD_W'($signed(s3_q.hh[i]));
      prod_d.p[i] = (t_hh << (2*LO_W)) + (t_hl << LO_W) + (t_lh << LO_W) + t_ll;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_q <= valid_i;
      end
      if (s4_ready) begin
        s4_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s3_ready) begin
      s3_q <= part_d;
    end
    if (s3_v_q && s4_ready) begin
      s4_q <= prod_d;
    end
  end

  assign valid_o    = s4_v_q;
  assign prod_o     = s4_q;
  assign kin_busy_o = (s3_v_q && is_kin(s3_q.meta.kind)) ||
                      (s4_v_q && is_kin(s4_q.meta.kind));

endmodule

@@ sv/cdff_round.sv @@
// Sum of products, round half up, arithmetic shift and saturation to Q23.24.
// Writes normal velocities back to the front stage. Depends on cdff_pkg.
module cdff_round import cdff_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  prod_t prod_i,
  output logic  valid_o,
  input  logic  ready_i,
  output rnd_t  rnd_o,
  output ufwr_t ufwr_o,
  output logic  kin_busy_o
);

  localparam logic signed [SUM_W-1:0] HALF_KIN  = SUM_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] HALF_FLUX = SUM_W'(1) << FRAC_W;

  logic s5_v_q;
  rnd_t s5_q;
  rnd_t rnd_d;
  logic s5_ready;
  logic kin;
  logic signed [SUM_W-1:0] flux_sum;
  logic signed [SUM_W-1:0] mass_sum;

  function automatic val_t round_sat(input logic signed [SUM_W-1:0] v, input logic k);
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] s;
    r = v + (k ? HALF_KIN : HALF_FLUX);
    s = k ? (r >>> FRAC_W) : (r >>> (FRAC_W + 1));
    if ((&s[SUM_W-1:VAL_W-1]) || !(|s[SUM_W-1:VAL_W-1])) begin
      return s[VAL_W-1:0];
    end
    return s[SUM_W-1] ? VAL_MIN : VAL_MAX;
  endfunction

  assign kin      = is_kin(prod_i.meta.kind);
  assign flux_sum = SUM_W'($signed(prod_i.p[0])) + SUM_W'($signed(prod_i.p[1])) +
                    SUM_W'($signed(prod_i.p[2]));
  assign mass_sum = SUM_W'($signed(prod_i.p[3]));

  always_comb begin
    rnd_d.meta = prod_i.meta;
    rnd_d.flux = round_sat(flux_sum, kin);
    rnd_d.mass = round_sat(mass_sum, 1'b0);
  end

  assign s5_ready = !s5_v_q || ready_i;
  assign ready_o  = s5_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (s5_ready) begin
      s5_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s5_ready) begin
      s5_q <= rnd_d;
    end
  end

  assign valid_o      = s5_v_q;
  assign rnd_o        = s5_q;
  assign ufwr_o.we    = s5_v_q && ready_i && is_kin(s5_q.meta.kind);
  assign ufwr_o.right = (s5_q.meta.kind == K_KIN_R);
  assign ufwr_o.value = s5_q.flux;
  assign kin_busy_o   = s5_v_q && is_kin(s5_q.meta.kind);

endmodule

@@ sv/cdff_out.sv @@
// Mass flux accumulator and result register; a z momentum item yields its
// momentum word and then the mass word. Depends on cdff_pkg.
module cdff_out import cdff_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rnd_t              rnd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COMP_W-1:0] flux_index_o,
  output val_t              flux_value_o,
  output logic              last_o
);

  logic              v6_q;
  logic              sel_q;
  logic              two_q;
  logic [COMP_W-1:0] idx_q;
  val_t              flux_q;
  val_t              mass_out_q;
  val_t              mass_q;

  logic              emits;
  logic              two;
  logic              take;
  logic              done;
  logic              free;
  logic              load;
  logic              step;
  logic [VAL_W:0]    mass_add;
  val_t              mass_new;

  assign emits = (rnd_i.meta.kind == K_MOM) || (rnd_i.meta.kind == K_ENERGY) ||
                 (rnd_i.meta.kind == K_SPECIES);
  assign two   = (rnd_i.meta.kind == K_MOM) && (rnd_i.meta.comp == COMP_MOM_Z);
  assign take  = v6_q && !out_stall_i;
  assign done  = take && (sel_q || !two_q);
  assign free  = !v6_q || done;
  assign ready_o = !emits || free;
  assign step  = valid_i && ready_o;
  assign load  = step && emits;

  assign mass_add = {mass_q[VAL_W-1], mass_q} + {rnd_i.mass[VAL_W-1], rnd_i.mass};
  assign mass_new = (mass_add[VAL_W] != mass_add[VAL_W-1]) ?
                    (mass_add[VAL_W] ? VAL_MIN : VAL_MAX) : mass_add[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      sel_q  <= 1'b0;
      mass_q <= '0;
    end else begin
      if (load) begin
        v6_q  <= 1'b1;
        sel_q <= 1'b0;
      end else if (done) begin
        v6_q <= 1'b0;
      end else if (take) begin
        sel_q <= 1'b1;
      end
      if (step && (rnd_i.meta.kind == K_AREA)) begin
        mass_q <= '0;
      end else if (step && (rnd_i.meta.kind == K_MOM)) begin
        mass_q <= two ? '0 : mass_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      two_q      <= two;
      idx_q      <= rnd_i.meta.comp;
      flux_q     <= rnd_i.flux;
      mass_out_q <= mass_new;
    end
  end

  assign out_valid_o  = v6_q;
  assign flux_index_o = sel_q ? COMP_MASS : idx_q;
  assign flux_value_o = sel_q ? mass_out_q : flux_q;
  assign last_o       = sel_q || !two_q;

endmodule

@@ sv/central_difference_face_flux_top.sv @@
// Central-difference face flux, Q23.24 datapath. Depends on cdff_pkg and the
// cdff_front, cdff_mul, cdff_round and cdff_out stages.
// Throughput: one word per cycle while nothing stalls; a z momentum word holds the
// output for its momentum word and then its mass word.
// A conserved-pair word right behind a kinematics word waits until that normal
// velocity is written back, longer while the output stalls the kinematics word.
// Async active-low reset clears valids and state.
module central_difference_face_flux_top import cdff_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FUNC_W-1:0]       func_i,
  input  logic signed [VAL_W-1:0] area_x_i,
  input  logic signed [VAL_W-1:0] area_y_i,
  input  logic signed [VAL_W-1:0] area_z_i,
  input  logic signed [VAL_W-1:0] vel_x_i,
  input  logic signed [VAL_W-1:0] vel_y_i,
  input  logic signed [VAL_W-1:0] vel_z_i,
  input  logic signed [VAL_W-1:0] pressure_i,
  input  logic [COMP_W-1:0]       component_i,
  input  logic signed [VAL_W-1:0] left_value_i,
  input  logic signed [VAL_W-1:0] right_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COMP_W-1:0]       flux_index_o,
  output logic signed [VAL_W-1:0] flux_value_o,
  output logic                    last_o
);

  logic  opnd_valid;
  logic  opnd_ready;
  opnd_t opnd;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod;
  logic  rnd_valid;
  logic  rnd_ready;
  rnd_t  rnd;
  ufwr_t ufwr;
  logic  mul_kin_busy;
  logic  rnd_kin_busy;

  cdff_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .area_x_i      (area_x_i),
    .area_y_i      (area_y_i),
    .area_z_i      (area_z_i),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .vel_z_i       (vel_z_i),
    .pressure_i    (pressure_i),
    .component_i   (component_i),
    .left_value_i  (left_value_i),
    .right_value_i (right_value_i),
    .ufwr_i        (ufwr),
    .kin_busy_i    (mul_kin_busy || rnd_kin_busy),
    .opnd_valid_o  (opnd_valid),
    .opnd_ready_i  (opnd_ready),
    .opnd_o        (opnd)
  );

  cdff_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (opnd_valid),
    .ready_o    (opnd_ready),
    .opnd_i     (opnd),
    .valid_o    (prod_valid),
    .ready_i    (prod_ready),
    .prod_o     (prod),
    .kin_busy_o (mul_kin_busy)
  );

  cdff_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (prod_valid),
    .ready_o    (prod_ready),
    .prod_i     (prod),
    .valid_o    (rnd_valid),
    .ready_i    (rnd_ready),
    .rnd_o      (rnd),
    .ufwr_o     (ufwr),
    .kin_busy_o (rnd_kin_busy)
  );

  cdff_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (rnd_valid),
    .ready_o      (rnd_ready),
    .rnd_i        (rnd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .flux_index_o (flux_index_o),
    .flux_value_o (flux_value_o),
    .last_o       (last_o)
  );

endmodule
